[rtl/pidx_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pidx_pkg
// Shared types and constants for the PNG IDAT chunk extractor.
// ---------------------------------------------------------------------------
package pidx_pkg;

	localparam int FILE_W = 24;  // file size, positions and summary fields
	localparam int BYTE_W = 8;
	localparam int SIG_LEN = 8;  // signature bytes skipped at file start
	localparam int HDR_CRC_LEN = 12;  // length + type + CRC bytes of a chunk
	localparam logic [31:0] IDAT_TAG = 32'h49444154;

	// Parser phase, one-hot
	typedef enum logic [5:0] {
		PH_SIG  = 6'b000001,
		PH_LEN  = 6'b000010,
		PH_TYPE = 6'b000100,
		PH_PAY  = 6'b001000,
		PH_CRC  = 6'b010000,
		PH_STOP = 6'b100000
	} pidx_phase_t;

	// One result record as handed from the parser to the output queue
	typedef struct packed {
		logic              is_summary;
		logic [BYTE_W-1:0] data;
		logic [FILE_W-1:0] first_pos;
		logic [FILE_W-1:0] total_length;
		logic [FILE_W-1:0] payload_size;
	} pidx_rec_t;

	typedef struct packed {
		logic      valid;
		pidx_rec_t rec;
	} pidx_push_t;

endpackage
`default_nettype wire

[rtl/pidx_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pidx_front
// Chunk walker: takes one file byte per transaction, tracks the chunk
// fields, keeps the IDAT statistics and builds result records.
// ---------------------------------------------------------------------------
module pidx_front import pidx_pkg::*; #(
	parameter int POS_BITS = 24
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [FILE_W-1:0] cfg_size,
	input  wire logic              in_fire,
	input  wire logic [BYTE_W-1:0] data_byte,
	output pidx_push_t             push
);

	localparam logic [POS_BITS-1:0] SAT_MAX = '1;

	logic [FILE_W-1:0]   size_q, pos_q, start_q;
	logic [FILE_W-1:0]   pos_d, start_d;
	pidx_phase_t         phase_q, phase_d;
	logic [1:0]          fidx_q, fidx_d;
	logic [31:0]         len_q, len_d, left_q, left_d;
	logic [23:0]         type_q, type_d;
	logic                idat_q, idat_d;
	logic [POS_BITS-1:0] first_q, first_d, total_q, total_d, pcount_q, pcount_d;

	logic [FILE_W-1:0] pos_inc;
	logic              active, last, emit, chunk_fits, len_over, type_is_idat;
	logic [31:0]       len_new, type_new;
	logic [33:0]       len_end, total_sum;

	assign pos_inc = pos_q + FILE_W'(1);
	assign len_new = {len_q[23:0], data_byte};
	assign type_new = {type_q, data_byte};
	assign type_is_idat = (type_new == IDAT_TAG);
	// room for a bare chunk header and CRC starting at the next byte
	assign chunk_fits = (26'(pos_inc) + 26'(HDR_CRC_LEN)) <= 26'(size_q);
	// full chunk extent against file end
	assign len_end = 34'(start_q) + 34'(HDR_CRC_LEN) + 34'(len_new);
	assign len_over = len_end > 34'(size_q);
	assign total_sum = 34'(total_q) + 34'(len_q) + 34'(HDR_CRC_LEN);

	// next-state logic
	always_comb begin
		pos_d = pos_q;
		start_d = start_q;
		phase_d = phase_q;
		fidx_d = fidx_q;
		len_d = len_q;
		left_d = left_q;
		type_d = type_q;
		idat_d = idat_q;
		first_d = first_q;
		total_d = total_q;
		pcount_d = pcount_q;
		emit = 1'b0;
		active = in_fire && (pos_q < size_q);
		last = (pos_inc == size_q);
		if (active) begin
			pos_d = pos_inc;
			case (phase_q)
				PH_SIG: begin
					if (pos_q >= FILE_W'(SIG_LEN - 1)) begin
						start_d = pos_inc;
						fidx_d = '0;
						len_d = '0;
						phase_d = chunk_fits ? PH_LEN : PH_STOP;
					end
				end
				PH_LEN: begin
					len_d = len_new;
					fidx_d = fidx_q + 2'd1;
					if (fidx_q == 2'd3) begin
						phase_d = len_over ? PH_STOP : PH_TYPE;
					end
				end
				PH_TYPE: begin
					type_d = type_new[23:0];
					fidx_d = fidx_q + 2'd1;
					if (fidx_q == 2'd3) begin
						idat_d = type_is_idat;
						if (type_is_idat) begin
							if (first_q == '0) begin
								first_d = (33'(start_q) > 33'(SAT_MAX)) ?
									SAT_MAX : POS_BITS'(start_q);
							end
							total_d = (total_sum > 34'(SAT_MAX)) ?
								SAT_MAX : POS_BITS'(total_sum);
						end
						left_d = len_q;
						phase_d = (len_q != '0) ? PH_PAY : PH_CRC;
					end
				end
				PH_PAY: begin
					if (idat_q) begin
						emit = 1'b1;
						pcount_d = (pcount_q == SAT_MAX) ? SAT_MAX : pcount_q + 1'b1;
					end
					left_d = left_q - 32'd1;
					if (left_q == 32'd1) begin
						phase_d = PH_CRC;
					end
				end
				PH_CRC: begin
					fidx_d = fidx_q + 2'd1;
					if (fidx_q == 2'd3) begin
						start_d = pos_inc;
						fidx_d = '0;
						len_d = '0;
						phase_d = chunk_fits ? PH_LEN : PH_STOP;
					end
				end
				PH_STOP: begin
					phase_d = PH_STOP;
				end
				default: begin
					phase_d = PH_STOP;
				end
			endcase
		end
	end

	// result record: summary on the final byte, else an IDAT payload byte
	always_comb begin
		push.valid = active && (last || emit);
		push.rec.is_summary = last;
		push.rec.data = data_byte;
		push.rec.first_pos = FILE_W'(first_d);
		push.rec.total_length = FILE_W'(total_d);
		push.rec.payload_size = FILE_W'(pcount_d);
	end

	// parser state; a file size write restarts the parse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			pos_q <= '0;
			start_q <= '0;
			phase_q <= PH_SIG;
			fidx_q <= '0;
			len_q <= '0;
			left_q <= '0;
			type_q <= '0;
			idat_q <= 1'b0;
			first_q <= '0;
			total_q <= '0;
			pcount_q <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_size;
			pos_q <= '0;
			start_q <= '0;
			phase_q <= PH_SIG;
			fidx_q <= '0;
			len_q <= '0;
			left_q <= '0;
			type_q <= '0;
			idat_q <= 1'b0;
			first_q <= '0;
			total_q <= '0;
			pcount_q <= '0;
		end else begin
			pos_q <= pos_d;
			start_q <= start_d;
			phase_q <= phase_d;
			fidx_q <= fidx_d;
			len_q <= len_d;
			left_q <= left_d;
			type_q <= type_d;
			idat_q <= idat_d;
			first_q <= first_d;
			total_q <= total_d;
			pcount_q <= pcount_d;
		end
	end

endmodule
`default_nettype wire

[rtl/pidx_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pidx_back
// Two-entry result queue; the head entry drives the output channel and is
// formatted into payload or summary fields.
// ---------------------------------------------------------------------------
module pidx_back import pidx_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pidx_push_t         push,
	output logic                    full,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    is_summary,
	output logic [BYTE_W-1:0]       payload_byte,
	output logic                    found,
	output logic [FILE_W-1:0]       first_pos,
	output logic [FILE_W-1:0]       total_length,
	output logic [FILE_W-1:0]       payload_size
);

	pidx_rec_t  entry_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       pop;
	pidx_rec_t  head;

	assign full = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop = out_valid && !out_stall;
	assign head = entry_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_q] <= push.rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push.valid, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// field formatting; summary fields hold zero unless IDAT payload was seen
	always_comb begin
		is_summary = head.is_summary;
		payload_byte = head.is_summary ? '0 : head.data;
		found = head.is_summary && (head.payload_size != '0);
		first_pos = found ? head.first_pos : '0;
		total_length = found ? head.total_length : '0;
		payload_size = head.is_summary ? head.payload_size : '0;
	end

endmodule
`default_nettype wire

[rtl/png_idat_chunk_extractor.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// png_idat_chunk_extractor
// Walks a PNG byte stream and emits IDAT payload bytes plus an end-of-file
// summary.
// ---------------------------------------------------------------------------
// Usage: write file_size first (each write restarts the parse), then feed
// the file one byte per transaction. The parser handles one byte per clock;
// each byte passes from the parser into a two-entry result queue whose head
// drives the output channel, so input is held off only when that queue is
// full. With the output side taking results, throughput is one byte per
// cycle and a result appears in the cycle after the byte that caused it.
// Bytes past file_size are taken and dropped. IDAT counts saturate at
// 2^POS_BITS - 1.
module png_idat_chunk_extractor import pidx_pkg::*; #(
	parameter int POS_BITS = 24
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [FILE_W-1:0] file_size,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] data_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   is_summary,
	output logic [BYTE_W-1:0]      payload_byte,
	output logic                   found,
	output logic [FILE_W-1:0]      first_pos,
	output logic [FILE_W-1:0]      total_length,
	output logic [FILE_W-1:0]      payload_size
);

	pidx_push_t push;
	logic       full;
	logic       in_fire;

	assign cfg_ready = 1'b1;
	assign in_stall = full;
	assign in_fire = in_valid && !full;

	// parser
	pidx_front #(
		.POS_BITS(POS_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_size(file_size),
		.in_fire(in_fire),
		.data_byte(data_byte),
		.push(push)
	);

	// result queue and output fields
	pidx_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_summary(is_summary),
		.payload_byte(payload_byte),
		.found(found),
		.first_pos(first_pos),
		.total_length(total_length),
		.payload_size(payload_size)
	);

endmodule
`default_nettype wire

[sim/tb_png_idat_chunk_extractor.sv]
// ---------------------------------------------------------------------------
// tb_png_idat_chunk_extractor
// Self-checking bench for the PNG IDAT chunk extractor. A byte-level parser
// model in the bench tracks each accepted file byte and queues the payload
// and end-of-file summary transactions the block should produce. Stimulus
// covers size extremes, a full-queue hold-off, and random PNG-like files
// (valid, truncated, padded, broken lengths) under several idle/stall mixes.
// ---------------------------------------------------------------------------
module tb_png_idat_chunk_extractor;
	import pidx_pkg::*;

	localparam logic [31:0] IHDR_TAG = 32'h49484452;
	localparam logic [31:0] IEND_TAG = 32'h49454E44;

	typedef struct {
		logic              is_summary;
		logic [BYTE_W-1:0] payload_byte;
		logic              found;
		logic [FILE_W-1:0] first_pos;
		logic [FILE_W-1:0] total_length;
		logic [FILE_W-1:0] payload_size;
	} idat_result_t;

	// DUT connections
	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [FILE_W-1:0] file_size;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] data_byte;
	logic              out_valid;
	logic              out_stall;
	logic              is_summary;
	logic [BYTE_W-1:0] payload_byte;
	logic              found;
	logic [FILE_W-1:0] first_pos;
	logic [FILE_W-1:0] total_length;
	logic [FILE_W-1:0] payload_size;

	// Parser model state
	logic [FILE_W-1:0] fsize_q;
	logic [FILE_W-1:0] byte_pos_q;
	pidx_phase_t       parse_phase;
	int unsigned       field_cnt_q;
	logic [31:0]       chunk_len_q;
	logic [31:0]       tag_q;
	logic [31:0]       left_q;
	logic              chunk_idat_q;
	logic              halted_q;
	logic [FILE_W-1:0] chunk_start_q;
	logic [FILE_W-1:0] first_idat_q;
	logic [FILE_W-1:0] idat_total_q;
	logic [FILE_W-1:0] payload_cnt_q;

	idat_result_t      idat_results_due[$];
	logic [BYTE_W-1:0] png_bytes[$];
	int                fault_count;
	int                send_idle_pct;
	int                rx_stall_pct;
	int                hold_request;

	png_idat_chunk_extractor u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.file_size    (file_size),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_summary   (is_summary),
		.payload_byte (payload_byte),
		.found        (found),
		.first_pos    (first_pos),
		.total_length (total_length),
		.payload_size (payload_size)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("png_idat_chunk_extractor verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------
	function automatic logic [FILE_W-1:0] sat_pos(input logic [63:0] v);
		return (v > 64'(FILE_W'('1))) ? '1 : v[FILE_W-1:0];
	endfunction

	function automatic void clear_parse_state();
		byte_pos_q    = '0;
		parse_phase   = PH_SIG;
		field_cnt_q   = 0;
		chunk_len_q   = '0;
		tag_q         = '0;
		left_q        = '0;
		chunk_idat_q  = 1'b0;
		halted_q      = 1'b0;
		chunk_start_q = '0;
		first_idat_q  = '0;
		idat_total_q  = '0;
		payload_cnt_q = '0;
	endfunction

	// Header plus CRC must fit before the length is even read
	function automatic void start_chunk(input logic [FILE_W-1:0] start);
		chunk_start_q = start;
		field_cnt_q   = 0;
		chunk_len_q   = '0;
		tag_q         = '0;
		chunk_idat_q  = 1'b0;
		if (64'(start) + HDR_CRC_LEN > 64'(fsize_q)) begin
			halted_q    = 1'b1;
			parse_phase = PH_STOP;
		end else begin
			parse_phase = PH_LEN;
		end
	endfunction

	function automatic void parse_png_byte(input logic [BYTE_W-1:0] b);
		logic         last_byte;
		logic         emit;
		idat_result_t r;
		// bytes past the end of the file are dropped silently
		if (64'(byte_pos_q) >= 64'(fsize_q))
			return;
		last_byte = (64'(byte_pos_q) + 64'd1 == 64'(fsize_q));
		emit      = 1'b0;
		if (!halted_q) begin
			case (parse_phase)
			PH_SIG: begin
				if (64'(byte_pos_q) + 64'd1 >= SIG_LEN)
					start_chunk(byte_pos_q + 1'b1);
			end
			PH_LEN: begin
				chunk_len_q = {chunk_len_q[23:0], b};
				field_cnt_q++;
				if (field_cnt_q >= 4) begin
					field_cnt_q = 0;
					// whole chunk must fit in the file
					if (64'(chunk_start_q) + HDR_CRC_LEN + 64'(chunk_len_q) >
					    64'(fsize_q)) begin
						halted_q    = 1'b1;
						parse_phase = PH_STOP;
					end else begin
						parse_phase = PH_TYPE;
					end
				end
			end
			PH_TYPE: begin
				tag_q = {tag_q[23:0], b};
				field_cnt_q++;
				if (field_cnt_q >= 4) begin
					field_cnt_q  = 0;
					chunk_idat_q = (tag_q == IDAT_TAG);
					if (chunk_idat_q) begin
						if (first_idat_q == '0)
							first_idat_q = chunk_start_q;
						idat_total_q = sat_pos(64'(idat_total_q) +
							64'(chunk_len_q) + HDR_CRC_LEN);
					end
					left_q      = chunk_len_q;
					parse_phase = (chunk_len_q != '0) ? PH_PAY : PH_CRC;
				end
			end
			PH_PAY: begin
				if (chunk_idat_q) begin
					emit          = 1'b1;
					payload_cnt_q = sat_pos(64'(payload_cnt_q) + 64'd1);
				end
				left_q--;
				if (left_q == '0)
					parse_phase = PH_CRC;
			end
			PH_CRC: begin
				field_cnt_q++;
				if (field_cnt_q >= 4)
					start_chunk(byte_pos_q + 1'b1);
			end
			default: begin
				halted_q    = 1'b1;
				parse_phase = PH_STOP;
			end
			endcase
		end
		byte_pos_q = byte_pos_q + 1'b1;

		// final byte gives the summary in place of any payload byte
		if (last_byte) begin
			r.is_summary   = 1'b1;
			r.payload_byte = '0;
			r.found        = (payload_cnt_q != '0);
			r.first_pos    = r.found ? first_idat_q : '0;
			r.total_length = r.found ? idat_total_q : '0;
			r.payload_size = payload_cnt_q;
			idat_results_due.push_back(r);
		end else if (emit) begin
			r.is_summary   = 1'b0;
			r.payload_byte = b;
			r.found        = 1'b0;
			r.first_pos    = '0;
			r.total_length = '0;
			r.payload_size = '0;
			idat_results_due.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor: config, input and output transactions in one process so
	// prediction always precedes the matching check
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		idat_result_t got;
		idat_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				fsize_q = file_size;
				clear_parse_state();
			end
			if (in_valid && !in_stall)
				parse_png_byte(data_byte);
			if (out_valid && !out_stall) begin
				got.is_summary   = is_summary;
				got.payload_byte = payload_byte;
				got.found        = found;
				got.first_pos    = first_pos;
				got.total_length = total_length;
				got.payload_size = payload_size;
				if (idat_results_due.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected result: sum=%0b byte=%h found=%0b pos=%h tot=%h cnt=%h",
							got.is_summary, got.payload_byte, got.found,
							got.first_pos, got.total_length, got.payload_size);
				end else begin
					want = idat_results_due.pop_front();
					if (got.is_summary !== want.is_summary ||
					    got.payload_byte !== want.payload_byte ||
					    got.found !== want.found ||
					    got.first_pos !== want.first_pos ||
					    got.total_length !== want.total_length ||
					    got.payload_size !== want.payload_size) begin
						fault_count++;
						if (fault_count <= 10) begin
							$display("mismatch exp: sum=%0b byte=%h found=%0b pos=%h tot=%h cnt=%h",
								want.is_summary, want.payload_byte, want.found,
								want.first_pos, want.total_length, want.payload_size);
							$display("         got: sum=%0b byte=%h found=%0b pos=%h tot=%h cnt=%h",
								got.is_summary, got.payload_byte, got.found,
								got.first_pos, got.total_length, got.payload_size);
						end
					end
				end
			end
		end
	end

	// Receiver stall; a requested hold-off is counted down here
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver tasks (entered and left at a falling edge)
	// ------------------------------------------------------------------
	task automatic put_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results(input int extra);
		in_valid <= 1'b0;
		while (idat_results_due.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_file_size(input logic [FILE_W-1:0] v);
		cfg_valid <= 1'b1;
		file_size <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			png_bytes.push_back(w[8*i +: 8]);
	endtask

	// Length field, type, payload of clen random bytes, random CRC
	task automatic push_chunk(input logic [31:0] tag, input logic [31:0] len_field,
	                          input int clen);
		push_word(len_field);
		push_word(tag);
		for (int i = 0; i < clen; i++)
			png_bytes.push_back(8'($urandom));
		push_word($urandom);
	endtask

	task automatic push_signature();
		if ($urandom_range(1))
			push_word(32'h89504E47);
		else
			push_word($urandom);
		push_word(32'h0D0A1A0A);
	endtask

	// Random PNG-like file; returns the size to program
	task automatic build_png(output logic [FILE_W-1:0] fsz);
		int          n_chunks;
		int          clen;
		int          kind;
		int          extra;
		logic [31:0] tag;
		logic [31:0] len_field;
		png_bytes.delete();
		push_signature();
		n_chunks = $urandom_range(4);
		for (int c = 0; c < n_chunks; c++) begin
			kind = $urandom_range(9);
			clen = ($urandom_range(6) == 0) ? 0 : $urandom_range(24);
			if (kind < 5)
				tag = IDAT_TAG;
			else if (kind == 5)
				tag = IHDR_TAG;
			else if (kind == 6)
				tag = IEND_TAG;
			else if (kind == 7)
				tag = IDAT_TAG ^ (32'd1 << $urandom_range(31));  // near miss
			else
				tag = $urandom;
			len_field = clen;
			if ($urandom_range(19) == 0)
				len_field = $urandom;  // broken length
			push_chunk(tag, len_field, clen);
		end
		kind = $urandom_range(19);
		if (kind < 14)
			fsz = png_bytes.size();
		else if (kind < 16)
			fsz = $urandom_range(png_bytes.size());  // truncated
		else if (kind < 18)
			fsz = png_bytes.size() + $urandom_range(1, 15);  // trailing junk
		else
			fsz = $urandom_range(12);  // short file
		while (png_bytes.size() < fsz)
			png_bytes.push_back(8'($urandom));
		while (png_bytes.size() > fsz)
			void'(png_bytes.pop_back());
		// a few bytes past the end, which the block drops
		extra = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (extra) png_bytes.push_back(8'($urandom));
	endtask

	task automatic send_png_bytes();
		foreach (png_bytes[i])
			put_byte(png_bytes[i]);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Zero size, one-byte file, signature-only file, largest size
	task automatic test_size_extremes();
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		write_file_size('0);
		put_byte(8'hFF);
		put_byte(8'h00);
		drain_results(8);

		write_file_size(24'd1);
		put_byte(8'hA5);
		put_byte(8'h5A);
		drain_results(8);

		png_bytes.delete();
		push_signature();
		write_file_size(FILE_W'(SIG_LEN));
		send_png_bytes();
		drain_results(8);

		// chunk length that runs past even the largest file stops the parse
		png_bytes.delete();
		push_signature();
		push_word(32'hFFFFFFFF);
		png_bytes.push_back(8'h00);
		write_file_size('1);
		send_png_bytes();
		drain_results(8);
	endtask

	// Long receiver hold-off fills the block; then a mid-file sender pause
	task automatic test_backpressure();
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		png_bytes.delete();
		push_signature();
		push_chunk(IDAT_TAG, 32'd40, 40);
		push_chunk(IDAT_TAG, 32'd6, 6);
		push_chunk(IEND_TAG, 32'd0, 0);
		write_file_size(FILE_W'(png_bytes.size()));
		hold_request = 80;
		for (int i = 0; i < 40; i++)
			put_byte(png_bytes[i]);
		drain_results(0);
		for (int i = 40; i < png_bytes.size(); i++)
			put_byte(png_bytes[i]);
		drain_results(8);
	endtask

	task automatic test_random_files(input int idle_pct, input int stall_pct,
	                                 input int budget);
		int                sent;
		logic [FILE_W-1:0] fsz;
		send_idle_pct = idle_pct;
		rx_stall_pct  = stall_pct;
		sent = 0;
		while (sent < budget) begin
			build_png(fsz);
			write_file_size(fsz);
			send_png_bytes();
			sent += png_bytes.size();
			drain_results(8);
		end
	endtask

	initial begin
		fault_count   = 0;
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		hold_request  = 0;
		fsize_q       = '0;
		clear_parse_state();
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		file_size = '0;
		in_valid  = 1'b0;
		data_byte = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_size_extremes();
		test_backpressure();
		test_random_files(0, 0, 450);
		test_random_files(88, 0, 450);
		test_random_files(0, 88, 450);
		test_random_files(13, 13, 450);

		drain_results(16);
		fault_count += idat_results_due.size();
		if (fault_count == 0)
			$display("png_idat_chunk_extractor verification clean");
		else
			$display("png_idat_chunk_extractor verification failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/pidx_pkg.sv
rtl/pidx_front.sv
rtl/pidx_back.sv
rtl/png_idat_chunk_extractor.sv
sim/tb_png_idat_chunk_extractor.sv
